[design/gbei_pkg.sv]
// Package for the GPIO bank edge interrupt core.
// Holds the bus word map, request kinds and the request/response structs.
// No dependencies.
`default_nettype none

package gbei_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int KIND_W = 2;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] word_t;

    // request kinds; the fourth code does nothing
    localparam kind_t KIND_READ  = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_TICK  = 2'd2;

    // register word map
    localparam addr_t ADDR_DATA       = 5'd0;
    localparam addr_t ADDR_DATA_SET   = 5'd1;
    localparam addr_t ADDR_DATA_CLR   = 5'd2;
    localparam addr_t ADDR_PULL_DIS   = 5'd3;
    localparam addr_t ADDR_DIR        = 5'd4;
    localparam addr_t ADDR_DIR_SET    = 5'd5;
    localparam addr_t ADDR_DIR_CLR    = 5'd6;
    localparam addr_t ADDR_ALT_FUNC   = 5'd8;
    localparam addr_t ADDR_RISE_MASK  = 5'd16;
    localparam addr_t ADDR_FALL_MASK  = 5'd17;
    localparam addr_t ADDR_INT_STATUS = 5'd18;
    localparam addr_t ADDR_INT_CLR    = 5'd19;

    typedef struct packed {
        kind_t kind;
        addr_t addr;
        word_t wdata;
        word_t pins;
    } req_t;

    typedef struct packed {
        word_t read_data;
        logic  irq;
        word_t drive_value;
        word_t drive_enable;
        word_t pull_enable;
        word_t alt_select;
    } rsp_t;

endpackage

`default_nettype wire

[design/gbei_edge_detect.sv]
// Edge detector: compares a pin sample with the previous one and picks out
// enabled rising and falling edges. Uses gbei_pkg.
`default_nettype none

module gbei_edge_detect
    import gbei_pkg::*;
(
    input  wire word_t pins,
    input  wire word_t last_pins,
    input  wire word_t rise_mask,
    input  wire word_t fall_mask,
    output word_t      edge_hits
);

    word_t rising;
    word_t falling;

    assign rising    = pins & ~last_pins;
    assign falling   = ~pins & last_pins;
    assign edge_hits = (rising & rise_mask) | (falling & fall_mask);

endmodule

`default_nettype wire

[design/gbei_regs.sv]
// Register bank: holds the pin control state, decodes bus requests and
// forms the response for each request. Uses gbei_pkg and gbei_edge_detect.
`default_nettype none

module gbei_regs
    import gbei_pkg::*;
#(
    parameter word_t PIN_MASK = '1
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        step,
    input  wire req_t  req,
    output rsp_t       rsp
);

    word_t data_latch_reg, data_latch_next;
    word_t direction_reg, direction_next;
    word_t pull_disable_reg, pull_disable_next;
    word_t alt_function_reg, alt_function_next;
    word_t rise_mask_reg, rise_mask_next;
    word_t fall_mask_reg, fall_mask_next;
    word_t int_status_reg, int_status_next;
    word_t last_pins_reg, last_pins_next;

    word_t wdata;
    word_t pins;
    word_t edge_hits;
    word_t rd;

    // drop bits of pins that do not exist
    assign wdata = req.wdata & PIN_MASK;
    assign pins  = req.pins & PIN_MASK;

    gbei_edge_detect u_edge (
        .pins      (pins),
        .last_pins (last_pins_reg),
        .rise_mask (rise_mask_reg),
        .fall_mask (fall_mask_reg),
        .edge_hits (edge_hits)
    );

    always_comb
    begin
        rd = '0;
        if (req.kind == KIND_READ)
        begin
            case (req.addr)
                ADDR_DATA:       rd = (data_latch_reg & direction_reg)
                                      | (last_pins_reg & ~direction_reg);
                ADDR_PULL_DIS:   rd = pull_disable_reg;
                ADDR_DIR:        rd = direction_reg;
                ADDR_ALT_FUNC:   rd = alt_function_reg;
                ADDR_RISE_MASK:  rd = rise_mask_reg;
                ADDR_FALL_MASK:  rd = fall_mask_reg;
                ADDR_INT_STATUS: rd = int_status_reg;
                default:         rd = '0;
            endcase
        end
    end

    always_comb
    begin
        data_latch_next   = data_latch_reg;
        direction_next    = direction_reg;
        pull_disable_next = pull_disable_reg;
        alt_function_next = alt_function_reg;
        rise_mask_next    = rise_mask_reg;
        fall_mask_next    = fall_mask_reg;
        int_status_next   = int_status_reg;
        last_pins_next    = last_pins_reg;
        if (req.kind == KIND_WRITE)
        begin
            case (req.addr)
                ADDR_DATA:      data_latch_next   = wdata;
                ADDR_DATA_SET:  data_latch_next   = data_latch_reg | wdata;
                ADDR_DATA_CLR:  data_latch_next   = data_latch_reg & ~wdata;
                ADDR_PULL_DIS:  pull_disable_next = wdata;
                ADDR_DIR:       direction_next    = wdata;
                ADDR_DIR_SET:   direction_next    = direction_reg | wdata;
                ADDR_DIR_CLR:   direction_next    = direction_reg & ~wdata;
                ADDR_ALT_FUNC:  alt_function_next = wdata;
                ADDR_RISE_MASK: rise_mask_next    = wdata;
                ADDR_FALL_MASK: fall_mask_next    = wdata;
                ADDR_INT_CLR:   int_status_next   = int_status_reg & ~wdata;
                default:        ;
            endcase
        end
        else if (req.kind == KIND_TICK)
        begin
            int_status_next = int_status_reg | edge_hits;
            last_pins_next  = pins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_latch_reg   <= '0;
            direction_reg    <= '0;
            pull_disable_reg <= '0;
            alt_function_reg <= '0;
            rise_mask_reg    <= '0;
            fall_mask_reg    <= '0;
            int_status_reg   <= '0;
            last_pins_reg    <= '0;
        end
        else if (step)
        begin
            data_latch_reg   <= data_latch_next;
            direction_reg    <= direction_next;
            pull_disable_reg <= pull_disable_next;
            alt_function_reg <= alt_function_next;
            rise_mask_reg    <= rise_mask_next;
            fall_mask_reg    <= fall_mask_next;
            int_status_reg   <= int_status_next;
            last_pins_reg    <= last_pins_next;
        end
    end

    // response shows the state after this request
    always_comb
    begin
        rsp.read_data    = rd;
        rsp.irq          = |int_status_next;
        rsp.drive_value  = data_latch_next;
        rsp.drive_enable = direction_next;
        rsp.pull_enable  = ~pull_disable_next & PIN_MASK;
        rsp.alt_select   = alt_function_next;
    end

    // status only ever holds bits of existing pins
    a_status_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int_status_reg & ~PIN_MASK) == '0)
        else $error("interrupt status holds bits beyond the pin count");

    // a tick always records the sample it was given
    a_tick_samples: assert property (@(posedge clk) disable iff (!rst_n)
        step && req.kind == KIND_TICK |=> last_pins_reg == $past(pins))
        else $error("pin sample not recorded on tick");

    // only a write to the clear word or a tick changes the status
    a_status_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && (req.kind == KIND_TICK
                   || (req.kind == KIND_WRITE && req.addr == ADDR_INT_CLR)))
        |=> $stable(int_status_reg))
        else $error("interrupt status changed without cause");

endmodule

`default_nettype wire

[design/gpio_bank_edge_interrupt_core.sv]
// GPIO bank edge interrupt core: one request (bus read, bus write or pin
// sample tick) is taken per clock while in_ready is high and its response
// passes through the request register and then the response register; with
// out_ready held high the core sustains one request per cycle. Uses gbei_pkg,
// gbei_regs and gbei_edge_detect.
`default_nettype none

module gpio_bank_edge_interrupt_core
    import gbei_pkg::*;
#(
    parameter int PIN_COUNT = 32
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  kind,
    input  wire  [4:0]  word_addr,
    input  wire  [31:0] write_data,
    input  wire  [31:0] pin_levels,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] read_data,
    output logic        irq_line,
    output logic [31:0] drive_value,
    output logic [31:0] drive_enable,
    output logic [31:0] pull_enable,
    output logic [31:0] alt_select
);

    localparam word_t PIN_MASK = {DATA_W{1'b1}} >> (DATA_W - PIN_COUNT);

    logic  req_valid_reg;
    req_t  req_reg;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp;
    logic  advance;

    // move the held request into the response register when it is free
    assign advance  = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.kind  <= kind;
            req_reg.addr  <= word_addr;
            req_reg.wdata <= write_data;
            req_reg.pins  <= pin_levels;
        end
        if (advance)
        begin
            rsp_reg <= rsp;
        end
    end

    gbei_regs #(
        .PIN_MASK (PIN_MASK)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (req_reg),
        .rsp   (rsp)
    );

    assign out_valid    = rsp_valid_reg;
    assign read_data    = rsp_reg.read_data;
    assign irq_line     = rsp_reg.irq;
    assign drive_value  = rsp_reg.drive_value;
    assign drive_enable = rsp_reg.drive_enable;
    assign pull_enable  = rsp_reg.pull_enable;
    assign alt_select   = rsp_reg.alt_select;

    // an accepted request is held until it moves on
    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |=> req_valid_reg && $stable(req_reg))
        else $error("held request lost or changed");

    // every request that moves on yields a response
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("response missing after advance");

    // no output bit for a pin that does not exist
    a_pins_masked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((pull_enable | drive_value | drive_enable
                            | alt_select | read_data) & ~PIN_MASK) == '0)
        else $error("output bit set beyond the pin count");

endmodule

`default_nettype wire
